### rtl/wti_pkg.sv
// ----------------------------------------------------------------------------
// wti_pkg
// Shared types and constants for the wrapping table interpolator.
// ----------------------------------------------------------------------------
package wti_pkg;

    localparam int TABLE_DEPTH     = 256;
    localparam int INDEX_FRAC_BITS = 16;

    localparam int ADDR_W    = $clog2(TABLE_DEPTH);
    localparam int LEN_W     = $clog2(TABLE_DEPTH + 1);
    localparam int INT_W     = 32 - INDEX_FRAC_BITS;
    localparam int CNT_W     = $clog2(INT_W);
    localparam int VALUE_W   = 32;
    localparam int DIFF_W    = VALUE_W + 1;
    localparam int PROD_W    = DIFF_W + INDEX_FRAC_BITS + 1;

    localparam int ENTRY_ADDR_W = 8;
    localparam int CFG_LEN_W    = 9;
    localparam int CFG_DATA_W   = 9;
    localparam int CFG_INDEX_W  = 1;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 32;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_SNAP_MODE    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_LENGTH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_RD0,
        ST_RD1,
        ST_MUL,
        ST_SUM,
        ST_DONE
    } state_t;

endpackage

### rtl/wti_ram.sv
// ----------------------------------------------------------------------------
// wti_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/wrapping_table_interpolator_core.sv
// ----------------------------------------------------------------------------
// wrapping_table_interpolator_core
// Wrapping lookup table with linear interpolation on a Q16.16 index.
// ----------------------------------------------------------------------------
// Input stream s_*: s_tuser selects the request kind (0 lookup, 1 write).
// A write request stores entry_value at entry_address and gives no result.
// A lookup request reduces the integer part of table_index modulo the table
// length with a bit-serial remainder unit (one index bit per cycle), reads
// one or two entries from the table RAM, then multiplies the fraction by the
// entry difference and rounds; snap mode returns the lower entry as read.
// Lookup steps: remainder, lower read, upper read, multiply, sum, done; snap
// mode skips multiply and sum, and an empty table goes straight to done.
// s_tready is low while a lookup works; writes are taken back to back.
// Output stream m_*: a register holds the result; the block accepts the next
// request while it waits. If the receiver stalls, a finished lookup waits in
// its last step until the output register frees.
// Config port: cfg_we/cfg_index/cfg_data; the user writes it only while idle (not enforced).
// Reset (aresetn, synchronous) clears the sequencer, output valid and both
// config registers; table contents are undefined until written.
// ----------------------------------------------------------------------------
module wrapping_table_interpolator_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [7:0] entry_address, [39:8] entry_value, [71:40] table_index
    input  logic [wti_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] command
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] result_value
    output logic [wti_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] table_empty
    output logic                            m_tuser,
    input  logic                            cfg_we,
    input  logic [wti_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [wti_pkg::CFG_DATA_W-1:0]  cfg_data
);

    wti_pkg::state_t state_reg, state_next;

    logic                                  snap_reg;
    logic [wti_pkg::CFG_LEN_W-1:0]         length_reg;
    logic [wti_pkg::LEN_W-1:0]             len_eff;

    logic [wti_pkg::INT_W-1:0]             ipart_reg, ipart_next;
    logic [wti_pkg::INDEX_FRAC_BITS-1:0]   frac_reg, frac_next;
    logic [wti_pkg::CNT_W-1:0]             cnt_reg, cnt_next;
    logic [wti_pkg::LEN_W-1:0]             rem_reg, rem_next;
    logic [wti_pkg::LEN_W:0]               trial;
    logic [wti_pkg::LEN_W-1:0]             q_idx;

    logic signed [wti_pkg::VALUE_W-1:0]    v0_reg, v0_next;
    logic signed [wti_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic signed [wti_pkg::DIFF_W-1:0]     diff;
    logic signed [wti_pkg::INDEX_FRAC_BITS:0] frac_s;
    logic signed [wti_pkg::PROD_W-1:0]     rounded;

    logic [wti_pkg::VALUE_W-1:0]           res_reg, res_next;
    logic                                  empty_reg, empty_next;

    logic                                  m_valid_reg, m_valid_next;
    logic [wti_pkg::VALUE_W-1:0]           m_data_reg, m_data_next;
    logic                                  m_empty_reg, m_empty_next;

    logic                                  s_accept;
    logic                                  out_free;
    logic [wti_pkg::ENTRY_ADDR_W-1:0]      in_addr;
    logic [wti_pkg::VALUE_W-1:0]           in_value;
    logic [31:0]                           in_index;

    logic                                  ram_we;
    logic [wti_pkg::ADDR_W-1:0]            ram_raddr;
    logic [wti_pkg::VALUE_W-1:0]           ram_rdata;

    function automatic logic [wti_pkg::DIFF_W-1:0] DIFF_EXT(
        input logic [wti_pkg::VALUE_W-1:0] v
    );
        return {v[wti_pkg::VALUE_W-1], v};
    endfunction

    assign in_addr  = s_tdata[7:0];
    assign in_value = s_tdata[39:8];
    assign in_index = s_tdata[71:40];

    assign s_tready = (state_reg == wti_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign len_eff = (32'(length_reg) > wti_pkg::TABLE_DEPTH)
                   ? wti_pkg::LEN_W'(wti_pkg::TABLE_DEPTH)
                   : wti_pkg::LEN_W'(length_reg);

    assign ram_we = s_accept && (s_tuser == wti_pkg::CMD_WRITE)
                 && (32'(in_addr) < wti_pkg::TABLE_DEPTH);

    // remainder step: shift in one index bit, subtract length if it fits
    assign trial = {rem_reg, ipart_reg[wti_pkg::INT_W-1]};

    assign q_idx = (rem_reg + 1'b1 == len_eff) ? '0 : rem_reg + 1'b1;

    // lower entry is read first, upper neighbor in the next cycle
    assign ram_raddr = (state_reg == wti_pkg::ST_RD0)
                     ? rem_reg[wti_pkg::ADDR_W-1:0]
                     : q_idx[wti_pkg::ADDR_W-1:0];

    assign diff    = $signed(DIFF_EXT(ram_rdata)) - $signed(DIFF_EXT(v0_reg));
    assign frac_s  = $signed({1'b0, frac_reg});
    assign rounded = (prod_reg + wti_pkg::PROD_W'(1 << (wti_pkg::INDEX_FRAC_BITS - 1)))
                     >>> wti_pkg::INDEX_FRAC_BITS;

    wti_ram #(
        .WIDTH(wti_pkg::VALUE_W),
        .DEPTH(wti_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wti_pkg::ADDR_W'(in_addr)),
        .wdata (in_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snap_reg   <= 1'b0;
            length_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                wti_pkg::REG_SNAP_MODE:    snap_reg   <= cfg_data[0];
                wti_pkg::REG_TABLE_LENGTH: length_reg <= cfg_data[wti_pkg::CFG_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wti_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        ipart_reg   <= ipart_next;
        frac_reg    <= frac_next;
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        v0_reg      <= v0_next;
        prod_reg    <= prod_next;
        res_reg     <= res_next;
        empty_reg   <= empty_next;
        m_data_reg  <= m_data_next;
        m_empty_reg <= m_empty_next;
    end

    always_comb begin
        state_next   = state_reg;
        ipart_next   = ipart_reg;
        frac_next    = frac_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        v0_next      = v0_reg;
        prod_next    = prod_reg;
        res_next     = res_reg;
        empty_next   = empty_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_empty_next = m_empty_reg;

        case (state_reg)
            wti_pkg::ST_IDLE: begin
                if (s_accept && (s_tuser == wti_pkg::CMD_LOOKUP)) begin
                    ipart_next = in_index[31:wti_pkg::INDEX_FRAC_BITS];
                    frac_next  = in_index[wti_pkg::INDEX_FRAC_BITS-1:0];
                    cnt_next   = wti_pkg::CNT_W'(wti_pkg::INT_W - 1);
                    rem_next   = '0;
                    if (len_eff == '0) begin
                        res_next   = '0;
                        empty_next = 1'b1;
                        state_next = wti_pkg::ST_DONE;
                    end else begin
                        empty_next = 1'b0;
                        state_next = wti_pkg::ST_DIV;
                    end
                end
            end
            wti_pkg::ST_DIV: begin
                if (trial >= {1'b0, len_eff}) begin
                    rem_next = wti_pkg::LEN_W'(trial - {1'b0, len_eff});
                end else begin
                    rem_next = trial[wti_pkg::LEN_W-1:0];
                end
                ipart_next = {ipart_reg[wti_pkg::INT_W-2:0], 1'b0};
                cnt_next   = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = wti_pkg::ST_RD0;
                end
            end
            wti_pkg::ST_RD0: begin
                state_next = wti_pkg::ST_RD1;
            end
            wti_pkg::ST_RD1: begin
                v0_next = ram_rdata;
                if (snap_reg) begin
                    res_next   = ram_rdata;
                    state_next = wti_pkg::ST_DONE;
                end else begin
                    state_next = wti_pkg::ST_MUL;
                end
            end
            wti_pkg::ST_MUL: begin
                prod_next  = diff * frac_s;
                state_next = wti_pkg::ST_SUM;
            end
            wti_pkg::ST_SUM: begin
                res_next   = v0_reg + rounded[wti_pkg::VALUE_W-1:0];
                state_next = wti_pkg::ST_DONE;
            end
            wti_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    m_empty_next = empty_reg;
                    state_next   = wti_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wti_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_empty_reg;

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("empty-table result is not zero");

    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == wti_pkg::ST_DIV |-> rem_reg < len_eff)
        else $error("remainder not below table length");

    a_q_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == wti_pkg::ST_RD0 |-> q_idx < len_eff)
        else $error("next index out of table");

    a_lookup_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tuser == wti_pkg::CMD_LOOKUP && len_eff != '0
        |=> state_reg == wti_pkg::ST_DIV)
        else $error("lookup did not start remainder");

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wrapping table interpolator core.
// ----------------------------------------------------------------------------
// A directed table covers the empty table, value and index extremes, the
// wrap of the upper neighbor to entry 0, snap mode and a length above the
// table depth. Random phases then reprogram snap mode and length, fill every
// entry a lookup can reach, and mix write and lookup requests. Each lookup
// result is predicted in the bench and checked in order. Both stream sides
// idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET   = 850;
    localparam int PHASE_ITEMS   = 60;
    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_REPORTS   = 10;
    localparam int NUM_DIRECTED  = 24;
    localparam longint ROUND_HALF = 64'sd1 <<< (wti_pkg::INDEX_FRAC_BITS - 1);

    typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        row_kind_t                        kind;
        logic                             cmd;
        logic [wti_pkg::ENTRY_ADDR_W-1:0] addr;
        logic [31:0]                      value;
        logic [31:0]                      index;
        logic [wti_pkg::CFG_INDEX_W-1:0]  cfg_index;
        logic [wti_pkg::CFG_DATA_W-1:0]   cfg_data;
        logic                             typed;
        logic [31:0]                      want_value;
        logic                             want_empty;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] value;
        logic        empty;
    } lookup_result_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [wti_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [wti_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tuser;
    logic                            cfg_we    = 1'b0;
    logic [wti_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [wti_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    logic [31:0]                   shadow_table [wti_pkg::TABLE_DEPTH];
    bit                            shadow_written [wti_pkg::TABLE_DEPTH];
    logic                          shadow_snap   = 1'b0;
    logic [wti_pkg::CFG_LEN_W-1:0] shadow_length = '0;

    lookup_result_t pending_results[$];
    lookup_result_t rx_got;
    lookup_result_t rx_want;
    stim_row_t      directed [NUM_DIRECTED];

    int mismatches    = 0;
    int cycle_count   = 0;
    int rx_wait       = 0;
    int requests_sent = 0;
    bit send_idling   = 1'b1;
    bit recv_idling   = 1'b1;

    wrapping_table_interpolator_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic lookup_result_t interpolate_entry(logic [31:0] index);
        lookup_result_t r;
        int unsigned    span;
        int unsigned    pos;
        int unsigned    nxt;
        longint         lo_val;
        longint         hi_val;
        longint         frac;
        r.value = '0;
        r.empty = 1'b1;
        span = (shadow_length > wti_pkg::TABLE_DEPTH) ? wti_pkg::TABLE_DEPTH : shadow_length;
        if (span == 0)
            return r;
        pos    = (index >> wti_pkg::INDEX_FRAC_BITS) % span;
        lo_val = $signed(shadow_table[pos]);
        r.empty = 1'b0;
        r.value = lo_val[31:0];
        if (!shadow_snap) begin
            nxt    = (pos + 1 == span) ? 0 : pos + 1;
            hi_val = $signed(shadow_table[nxt]);
            frac   = index[wti_pkg::INDEX_FRAC_BITS-1:0];
            lo_val = lo_val + (((hi_val - lo_val) * frac + ROUND_HALF)
                               >>> wti_pkg::INDEX_FRAC_BITS);
            r.value = lo_val[31:0];
        end
        return r;
    endfunction

    function automatic void enqueue_result(lookup_result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic stim_row_t row_config(logic [wti_pkg::CFG_INDEX_W-1:0] which,
                                             int data);
        stim_row_t r;
        r           = '0;
        r.kind      = ROW_CONFIG;
        r.cfg_index = which;
        r.cfg_data  = data[wti_pkg::CFG_DATA_W-1:0];
        return r;
    endfunction

    function automatic stim_row_t row_request(logic cmd,
                                              logic [wti_pkg::ENTRY_ADDR_W-1:0] addr,
                                              logic [31:0] value, logic [31:0] index);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_REQUEST;
        r.cmd   = cmd;
        r.addr  = addr;
        r.value = value;
        r.index = index;
        return r;
    endfunction

    function automatic stim_row_t row_known(logic [31:0] index, logic [31:0] want_value,
                                            logic want_empty);
        stim_row_t r;
        r            = row_request(wti_pkg::CMD_LOOKUP, '0, '0, index);
        r.typed      = 1'b1;
        r.want_value = want_value;
        r.want_empty = want_empty;
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_index();
        logic [31:0] index;
        index = $urandom;
        case ($urandom_range(0, 7))
            0: index[wti_pkg::INDEX_FRAC_BITS-1:0] = '0;
            1: index[wti_pkg::INDEX_FRAC_BITS-1:0] = '1;
            2: begin
                index[wti_pkg::INDEX_FRAC_BITS-1:0] = '0;
                index[wti_pkg::INDEX_FRAC_BITS-1]   = 1'b1;
            end
            3: index = index >> 8;
            4: index = '1;
            default: ;
        endcase
        return index;
    endfunction

    function automatic void log_mismatch(string what, lookup_result_t want, lookup_result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t: %s: expected value %h empty %b, got value %h empty %b",
                     $time, what, want.value, want.empty, got.value, got.empty);
    endfunction

    // result check and receiver stalls
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            rx_got.value = m_tdata;
            rx_got.empty = m_tuser;
            if (pending_results.size() == 0) begin
                log_mismatch("result with no lookup pending", '0, rx_got);
            end else begin
                rx_want = pending_results.pop_front();
                if (rx_got.value !== rx_want.value)
                    log_mismatch("result_value", rx_want, rx_got);
                if (rx_got.empty !== rx_want.empty)
                    log_mismatch("table_empty", rx_want, rx_got);
            end
            rx_wait = recv_idling ? $urandom_range(0, 3) : 0;
        end else if (rx_wait > 0) begin
            rx_wait--;
        end
        m_tready <= aresetn && (rx_wait == 0);
    end

    task automatic write_register(logic [wti_pkg::CFG_INDEX_W-1:0] which,
                                  logic [wti_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (which == wti_pkg::REG_SNAP_MODE)
            shadow_snap = data[0];
        else
            shadow_length = data;
    endtask

    task automatic send_request(logic cmd, logic [wti_pkg::ENTRY_ADDR_W-1:0] addr,
                                logic [31:0] value, logic [31:0] index, logic typed,
                                lookup_result_t want);
        int gap;
        gap = send_idling ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {index, value, addr};
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        if (cmd == wti_pkg::CMD_WRITE) begin
            shadow_table[addr]   = value;
            shadow_written[addr] = 1'b1;
        end else begin
            enqueue_result(typed ? want : interpolate_entry(index));
        end
    endtask

    // drain all lookups, then give the core time to go idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        stim_row_t                      row;
        lookup_result_t                 want;
        logic                           snap;
        logic [wti_pkg::CFG_DATA_W-1:0] length;
        int                             phase;

        directed = '{
            row_known(32'h0000_0000, 32'h0000_0000, 1'b1),
            row_known(32'hFFFF_FFFF, 32'h0000_0000, 1'b1),
            row_request(wti_pkg::CMD_WRITE, 8'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF),
            row_request(wti_pkg::CMD_WRITE, 8'd1, 32'h8000_0000, 32'h0000_0000),
            row_request(wti_pkg::CMD_WRITE, 8'd2, 32'h0000_0000, 32'h0000_0000),
            row_request(wti_pkg::CMD_WRITE, 8'd3, 32'h0001_0000, 32'h0000_0000),
            row_request(wti_pkg::CMD_WRITE, 8'd255, 32'hFFFF_FFFF, 32'h0000_0000),
            row_config(wti_pkg::REG_TABLE_LENGTH, 4),
            row_known(32'h0000_0000, 32'h7FFF_FFFF, 1'b0),
            row_request(wti_pkg::CMD_LOOKUP, 8'd0, 32'h0000_0000, 32'h0000_8000),
            row_request(wti_pkg::CMD_LOOKUP, 8'hFF, 32'hFFFF_FFFF, 32'h0001_FFFF),
            row_request(wti_pkg::CMD_LOOKUP, 8'd0, 32'h0000_0000, 32'h0003_8000),
            row_request(wti_pkg::CMD_LOOKUP, 8'd0, 32'h0000_0000, 32'hFFFF_FFFF),
            row_known(32'h0004_0000, 32'h7FFF_FFFF, 1'b0),
            row_config(wti_pkg::REG_SNAP_MODE, 1),
            row_known(32'h0001_FFFF, 32'h8000_0000, 1'b0),
            row_known(32'hFFFF_FFFF, 32'h0001_0000, 1'b0),
            row_config(wti_pkg::REG_TABLE_LENGTH, 511),
            row_known(32'h00FF_1234, 32'hFFFF_FFFF, 1'b0),
            row_config(wti_pkg::REG_SNAP_MODE, 0),
            row_request(wti_pkg::CMD_LOOKUP, 8'd0, 32'h0000_0000, 32'h00FF_8000),
            row_request(wti_pkg::CMD_LOOKUP, 8'd0, 32'h0000_0000, 32'h0000_C000),
            row_config(wti_pkg::REG_TABLE_LENGTH, 0),
            row_known(32'h0001_0000, 32'h0000_0000, 1'b1)
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            row = directed[i];
            if (row.kind == ROW_CONFIG) begin
                settle();
                write_register(row.cfg_index, row.cfg_data);
            end else begin
                want.value = row.want_value;
                want.empty = row.want_empty;
                send_request(row.cmd, row.addr, row.value, row.index, row.typed, want);
            end
        end

        phase = 0;
        while (requests_sent < ITEM_TARGET) begin
            settle();
            case (phase)
                0: begin
                    snap   = 1'b0;
                    length = wti_pkg::CFG_DATA_W'(1);
                end
                1: begin
                    snap   = 1'b1;
                    length = wti_pkg::CFG_DATA_W'(wti_pkg::TABLE_DEPTH);
                end
                2: begin
                    snap   = 1'b0;
                    length = '1;
                end
                3: begin
                    snap   = 1'b1;
                    length = '0;
                end
                default: begin
                    snap = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 7))
                        0: length = wti_pkg::CFG_DATA_W'(2);
                        1: length = wti_pkg::CFG_DATA_W'($urandom_range(
                               wti_pkg::TABLE_DEPTH + 1, (1 << wti_pkg::CFG_LEN_W) - 1));
                        default: length = wti_pkg::CFG_DATA_W'($urandom_range(
                               1, wti_pkg::TABLE_DEPTH));
                    endcase
                end
            endcase
            write_register(wti_pkg::REG_SNAP_MODE, wti_pkg::CFG_DATA_W'(snap));
            write_register(wti_pkg::REG_TABLE_LENGTH, length);
            send_idling = $urandom_range(0, 3) != 0;
            recv_idling = $urandom_range(0, 3) != 0;

            // every entry a lookup can reach must hold a value
            for (int a = 0; a < wti_pkg::TABLE_DEPTH && a < length; a++)
                if (!shadow_written[a])
                    send_request(wti_pkg::CMD_WRITE, wti_pkg::ENTRY_ADDR_W'(a), pick_value(),
                                 $urandom, 1'b0, '0);

            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 3) == 0)
                    send_request(wti_pkg::CMD_WRITE, wti_pkg::ENTRY_ADDR_W'($urandom),
                                 pick_value(), $urandom, 1'b0, '0);
                else
                    send_request(wti_pkg::CMD_LOOKUP, wti_pkg::ENTRY_ADDR_W'($urandom),
                                 $urandom, pick_index(), 1'b0, '0);
            end
            phase++;
        end

        settle();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
